// ===== rtl/bfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types and constants of the byte ring FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package bfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 11;
    localparam int CAP_W     = 4;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd10;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_DROP = 2'd3
    } bfr_cmd_t;

    typedef struct packed {
        logic             show_byte;
        logic             accepted;
        logic [CNT_W-1:0] used_count;
        logic [CNT_W-1:0] free_count;
        logic             is_empty;
        logic             is_full;
    } bfr_status_t;

endpackage

`default_nettype wire

// ===== rtl/byte_ring_fifo.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo
// Byte FIFO in a power-of-two ring with push, pop, peek and drop commands.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata / data                       | tuser
//  s_axis   | in        | push_byte, amount                  | command
//  m_axis   | out       | read_byte, accepted, used, free,   | -
//           |           | is_empty, is_full                  |
//  cfg      | in        | capacity_log2                      | -
//
//  One item per cycle while the result is not stalled and no clearing pass
//  runs; a result passes the RAM read register, then the result register.
//  After reset a clearing pass zeroes every ring entry; s_axis_tready
//  stays low meanwhile. Configuration writes are taken at any time.
//  A stalled result holds; one more item waits in the RAM read stage.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo #(
    parameter int DEPTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // push_byte[7:0], amount[18:8], zero
    input  wire logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_byte[7:0], accepted[8], used_count[19:9], free_count[30:20],
    // is_empty[31], is_full[32], zero
    output logic      [39:0] m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data        // capacity_log2
);

    import bfr_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              clr_active_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic              s1_valid_reg;
    bfr_status_t       s1_stat_reg;
    logic              out_valid_reg;
    bfr_status_t       out_stat_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] out_byte_next;

    logic              accept;
    logic              s1_move;
    logic              push_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    bfr_status_t       status;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;

    assign cfg_ready     = 1'b1;
    assign s1_move       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !clr_active_reg && (!s1_valid_reg || s1_move);
    assign accept        = s_axis_tvalid && s_axis_tready;

    bfr_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_valid),
        .cfg_cap (cfg_data),
        .item_we (accept),
        .command (s_axis_tuser),
        .amount  (s_axis_tdata[18:8]),
        .push_en (push_en),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .status  (status)
    );

    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = accept && push_en;
            ram_waddr = wr_addr;
            ram_wdata = s_axis_tdata[7:0];
        end
        out_byte_next = s1_stat_reg.show_byte ? ram_rdata : '0;
    end

    bfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_stat_reg <= status;
        end
        if (s1_move)
        begin
            out_stat_reg <= s1_stat_reg;
            out_byte_reg <= out_byte_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_stat_reg.is_full, out_stat_reg.is_empty,
                            out_stat_reg.free_count, out_stat_reg.used_count,
                            out_stat_reg.accepted, out_byte_reg};

endmodule

`default_nettype wire

// ===== rtl/bfr_ram.sv =====
// ----------------------------------------------------------------------------
// bfr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bfr_ptr.sv =====
// ----------------------------------------------------------------------------
// bfr_ptr
// Ring positions, active size, command decode and fill status per item.
// ----------------------------------------------------------------------------
`default_nettype none

module bfr_ptr #(
    parameter int DEPTH = 1024
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [bfr_pkg::CAP_W-1:0] cfg_cap,
    input  wire logic                      item_we,
    input  wire logic [1:0]                command,
    input  wire logic [bfr_pkg::CNT_W-1:0] amount,
    output logic                           push_en,
    output logic      [$clog2(DEPTH)-1:0]  wr_addr,
    output logic      [$clog2(DEPTH)-1:0]  rd_addr,
    output bfr_pkg::bfr_status_t           status
);

    import bfr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int PW = AW + 1;
    localparam int CW = (PW > CNT_W) ? PW : CNT_W;

    logic [CAP_W-1:0] cap_reg;
    logic [PW-1:0]    wp_reg;
    logic [PW-1:0]    rp_reg;
    logic [PW-1:0]    wp_next;
    logic [PW-1:0]    rp_next;

    logic [PW-1:0]    size;
    logic [AW-1:0]    amask;
    logic [PW-1:0]    used;
    logic [PW-1:0]    used_next;
    logic [PW-1:0]    free;
    logic             pop_en;
    logic             peek_en;
    bfr_cmd_t         cmd;

    always_comb
    begin
        cmd = bfr_cmd_t'(command);
        if ((AW <= 15) && (cap_reg >= CAP_W'(AW)))
        begin
            size = PW'(DEPTH);
        end
        else
        begin
            size = PW'(1) << cap_reg;
        end
        amask = AW'(size - PW'(1));
        used  = wp_reg - rp_reg;

        wp_next = wp_reg;
        rp_next = rp_reg;
        push_en = 1'b0;
        pop_en  = 1'b0;
        peek_en = 1'b0;
        wr_addr = wp_reg[AW-1:0] & amask;
        rd_addr = rp_reg[AW-1:0] & amask;

        case (cmd)
            CMD_PUSH:
            begin
                if (used < size)
                begin
                    push_en = 1'b1;
                    wp_next = wp_reg + PW'(1);
                end
            end
            CMD_POP:
            begin
                if (used != '0)
                begin
                    pop_en  = 1'b1;
                    rp_next = rp_reg + PW'(1);
                end
            end
            CMD_PEEK:
            begin
                peek_en = 1'b1;
                rd_addr = (rp_reg[AW-1:0] + AW'(amount)) & amask;
            end
            CMD_DROP:
            begin
                if (CW'(amount) >= CW'(used))
                begin
                    rp_next = wp_reg;
                end
                else
                begin
                    rp_next = rp_reg + PW'(amount);
                end
            end
            default:
            begin
                rp_next = rp_reg;
            end
        endcase

        used_next = wp_next - rp_next;
        free      = (used_next < size) ? (size - used_next) : '0;

        status.show_byte  = pop_en | peek_en;
        status.accepted   = pop_en | push_en;
        status.used_count = CNT_W'(used_next);
        status.free_count = CNT_W'(free);
        status.is_empty   = (used_next == '0);
        status.is_full    = (used_next >= size);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
            wp_reg  <= '0;
            rp_reg  <= '0;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_cap;
            wp_reg  <= '0;
            rp_reg  <= '0;
        end
        else if (item_we)
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bfr_checker.sv =====
// ----------------------------------------------------------------------------
// bfr_checker
// Port-level checks of the byte ring FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bfr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);

    a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31] == (m_axis_tdata[19:9] == 11'd0)))
        else $error("is_empty disagrees with used_count");

    a_full_no_free: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[32]) |-> (m_axis_tdata[30:20] == 11'd0))
        else $error("full result reports free space");

    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without an item taken two cycles before");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind byte_ring_fifo bfr_checker u_bfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
